// ----- rtl/idsc_pkg.sv -----
// Shared types, constants and the sRGB-to-linear table for the image
// difference statistics core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package idsc_pkg;

  // result kinds
  localparam logic [1:0] KIND_DIFF    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_TOL_RED   = 3'd1;
  localparam logic [2:0] REG_TOL_GREEN = 3'd2;
  localparam logic [2:0] REG_TOL_BLUE  = 3'd3;
  localparam logic [2:0] REG_TOL_ALPHA = 3'd4;
  localparam logic [2:0] REG_RMSE      = 3'd5;
  localparam logic [2:0] REG_PERCEPT   = 3'd6;

  // compare modes
  localparam logic [1:0] MODE_EXACT     = 2'd0;
  localparam logic [1:0] MODE_TOLERANCE = 2'd1;
  localparam logic [1:0] MODE_RMSE      = 2'd2;
  localparam logic [1:0] MODE_PERCEPT   = 2'd3;

  // job numbers of the final pass: 0..3 channels, then overall, then luma
  localparam logic [2:0] JOB_OVERALL = 3'd4;
  localparam logic [2:0] JOB_LUMA    = 3'd5;

  localparam int RadW  = 56;  // divider dividend / root radicand width
  localparam int RootW = 28;
  localparam int CfgW  = 17;

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  typedef struct packed {
    logic [7:0] ref_red;
    logic [7:0] ref_green;
    logic [7:0] ref_blue;
    logic [7:0] ref_alpha;
    logic [7:0] act_red;
    logic [7:0] act_green;
    logic [7:0] act_blue;
    logic [7:0] act_alpha;
    logic       last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  diff_red;
    logic [7:0]  diff_green;
    logic [7:0]  diff_blue;
    logic [1:0]  channel_number;
    logic [7:0]  max_error;
    logic [15:0] channel_rms;
    logic [15:0] overall_rms;
    logic [16:0] luma_error;
    logic [20:0] differing_count;
    logic        matches_res;
    logic        last_result;
  } res_out_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       mul;
    logic       luma;
    logic       acc;
    logic       div_go;
    logic       sqrt_go;
    logic       keep;
    logic       emit;
    logic [2:0] job;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic div_done;
    logic sqrt_done;
    logic last;
  } sts_t;

  typedef logic [15:0] lin_tab_t [256];

  // UQ0.16 linear value of an sRGB byte, round half up, saturated
  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    real      x;
    int       v;
    for (int n = 0; n < 256; n++) begin
      if (n <= 10) begin
        v = (655360 * n + 16473) / 32946;
      end else begin
        x = (1000.0 * n + 14025.0) / 269025.0;
        x = (x ** 2.4) * 65536.0 + 0.5;
        v = $rtoi(x);
      end
      if (v > 65535) v = 65535;
      t[n] = v[15:0];
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin();

endpackage
`default_nettype wire

// ----- rtl/idsc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on idsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idsc_div #(
  parameter int DvW = 23
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [idsc_pkg::RadW-1:0] dividend_i,
  input  wire logic [DvW-1:0]         divisor_i,
  output logic [idsc_pkg::RadW-1:0]   quotient_o,
  output logic                        done_o
);
  import idsc_pkg::*;

  localparam int CntW = $clog2(RadW);

  logic [RadW-1:0] quo_q, quo_d;
  logic [DvW-1:0]  rem_q, rem_d, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DvW:0]    shifted, diff;
  logic            ge;

  always_comb begin
    shifted = {rem_q, quo_q[RadW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? diff[DvW-1:0] : shifted[DvW-1:0];
    quo_d   = {quo_q[RadW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(RadW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;
endmodule
`default_nettype wire

// ----- rtl/idsc_sqrt.sv -----
// Integer square root, one root bit (two radicand bits) per cycle.
// Depends on idsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idsc_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [idsc_pkg::RadW-1:0]  radicand_i,
  output logic [idsc_pkg::RootW-1:0]      root_o,
  output logic                            done_o
);
  import idsc_pkg::*;

  localparam int CntW = $clog2(RootW);

  logic [RadW-1:0]  x_q;
  logic [RootW+1:0] rem_q, rem_d;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [RootW+3:0] shifted, trial, diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, x_q[RadW-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    diff    = shifted - trial;
    ge      = shifted >= trial;
    rem_d   = ge ? diff[RootW+1:0] : shifted[RootW+1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[RadW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

// ----- rtl/idsc_dp.sv -----
// Datapath: pixel capture, luma pipeline, accumulators, config registers,
// final divide/root unit and output register. Depends on idsc_pkg,
// idsc_div and idsc_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module idsc_dp #(
  parameter int MAX_PIXELS = 1048576
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire idsc_pkg::pix_in_t          in_data_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic [2:0]                 cfg_index_i,
  input  wire logic [idsc_pkg::CfgW-1:0]  cfg_data_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output idsc_pkg::res_out_t              out_data_o,
  input  wire idsc_pkg::cmd_t             cmd_i,
  output idsc_pkg::sts_t                  sts_o
);
  import idsc_pkg::*;

  localparam int CntW = $clog2(MAX_PIXELS + 1);
  localparam int DvW  = CntW + 2;
  localparam int ExtW = (CntW > 21) ? CntW : 21;

  // configuration
  logic [1:0]  mode_q;
  logic [7:0]  tol_q [4];
  logic [15:0] rmse_lim_q;
  logic [16:0] perc_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_EXACT;
      tol_q      <= '{default: '0};
      rmse_lim_q <= '0;
      perc_lim_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE:      mode_q     <= cfg_data_i[1:0];
        REG_TOL_RED:   tol_q[0]   <= cfg_data_i[7:0];
        REG_TOL_GREEN: tol_q[1]   <= cfg_data_i[7:0];
        REG_TOL_BLUE:  tol_q[2]   <= cfg_data_i[7:0];
        REG_TOL_ALPHA: tol_q[3]   <= cfg_data_i[7:0];
        REG_RMSE:      rmse_lim_q <= cfg_data_i[15:0];
        REG_PERCEPT:   perc_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture stage: abs diffs and table lookups
  logic [7:0]  refv [4];
  logic [7:0]  actv [4];
  logic [7:0]  absd_q [4];
  logic [15:0] lin_r_q [3];
  logic [15:0] lin_a_q [3];
  logic        last_q;
  logic [31:0] prod_r_q [3];
  logic [31:0] prod_a_q [3];
  logic [16:0] dl_q;

  assign refv = '{in_data_i.ref_red, in_data_i.ref_green, in_data_i.ref_blue,
                  in_data_i.ref_alpha};
  assign actv = '{in_data_i.act_red, in_data_i.act_green, in_data_i.act_blue,
                  in_data_i.act_alpha};

  logic [15:0] wt [3];
  assign wt = '{W_RED, W_GREEN, W_BLUE};

  logic [33:0] sum_r, sum_a;
  logic [16:0] luma_r, luma_a;

  always_comb begin
    sum_r  = 34'(prod_r_q[0]) + 34'(prod_r_q[1]) + 34'(prod_r_q[2]) + 34'd32768;
    sum_a  = 34'(prod_a_q[0]) + 34'(prod_a_q[1]) + 34'(prod_a_q[2]) + 34'd32768;
    luma_r = sum_r[32:16];
    luma_a = sum_a[32:16];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int c = 0; c < 4; c++) begin
        absd_q[c] <= (actv[c] > refv[c]) ? actv[c] - refv[c] : refv[c] - actv[c];
      end
      for (int c = 0; c < 3; c++) begin
        lin_r_q[c] <= LIN_TABLE[refv[c]];
        lin_a_q[c] <= LIN_TABLE[actv[c]];
      end
      last_q <= in_data_i.last_pixel;
    end
    if (cmd_i.mul) begin
      for (int c = 0; c < 3; c++) begin
        prod_r_q[c] <= 32'(lin_r_q[c]) * 32'(wt[c]);
        prod_a_q[c] <= 32'(lin_a_q[c]) * 32'(wt[c]);
      end
    end
    if (cmd_i.luma) begin
      dl_q <= (luma_a > luma_r) ? luma_a - luma_r : luma_r - luma_a;
    end
  end

  // accumulators
  logic [35:0]     sq_q [4];
  logic [7:0]      max_q [4];
  logic [CntW-1:0] pix_q, dif_q;
  logic            within_q;
  logic [53:0]     lsq_q;
  logic [36:0]     sq_new [4];
  logic [54:0]     lsq_new;
  logic            differs, tol_ok;

  always_comb begin
    differs = 1'b0;
    tol_ok  = 1'b1;
    for (int c = 0; c < 4; c++) begin
      sq_new[c] = 37'(sq_q[c]) + 37'(absd_q[c]) * 37'(absd_q[c]);
      if (absd_q[c] != 8'd0) differs = 1'b1;
      if (absd_q[c] > tol_q[c]) tol_ok = 1'b0;
    end
    lsq_new = 55'(lsq_q) + 55'(dl_q) * 55'(dl_q);
  end

  logic clear;
  assign clear = cmd_i.emit && (cmd_i.job == JOB_OVERALL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q     <= '{default: '0};
      max_q    <= '{default: '0};
      pix_q    <= '0;
      dif_q    <= '0;
      within_q <= 1'b1;
      lsq_q    <= '0;
    end else if (clear) begin
      sq_q     <= '{default: '0};
      max_q    <= '{default: '0};
      pix_q    <= '0;
      dif_q    <= '0;
      within_q <= 1'b1;
      lsq_q    <= '0;
    end else if (cmd_i.acc) begin
      for (int c = 0; c < 4; c++) begin
        sq_q[c] <= sq_new[c][36] ? '1 : sq_new[c][35:0];
        if (absd_q[c] > max_q[c]) max_q[c] <= absd_q[c];
      end
      lsq_q <= lsq_new[54] ? '1 : lsq_new[53:0];
      if (pix_q < CntW'(MAX_PIXELS)) pix_q <= pix_q + 1'b1;
      if (differs && dif_q < CntW'(MAX_PIXELS)) dif_q <= dif_q + 1'b1;
      if (!tol_ok) within_q <= 1'b0;
    end
  end

  // final divide and root
  logic [37:0]      total;
  logic [RadW-1:0]  dividend, quotient;
  logic [DvW-1:0]   divisor;
  logic [RootW-1:0] root;
  logic             div_done, sqrt_done;
  logic [16:0]      res_q [6];
  logic [1:0]       jch;

  assign jch = cmd_i.job[1:0];

  always_comb begin
    total = 38'(sq_q[0]) + 38'(sq_q[1]) + 38'(sq_q[2]) + 38'(sq_q[3]);
    if (cmd_i.job == JOB_LUMA) begin
      dividend = RadW'(lsq_q);
      divisor  = DvW'(pix_q);
    end else if (cmd_i.job == JOB_OVERALL) begin
      dividend = RadW'({total, 16'h0000});
      divisor  = {pix_q, 2'b00};
    end else begin
      dividend = RadW'({sq_q[jch], 16'h0000});
      divisor  = DvW'(pix_q);
    end
  end

  idsc_div #(.DvW(DvW)) u_div (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.div_go),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  idsc_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.sqrt_go),
    .radicand_i (quotient),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.keep) begin
      if (cmd_i.job == JOB_LUMA) begin
        res_q[cmd_i.job] <= (root > RootW'(65536)) ? 17'h10000 : root[16:0];
      end else begin
        res_q[cmd_i.job] <= (root > RootW'(65535)) ? 17'h0FFFF : root[16:0];
      end
    end
  end

  // output register
  logic       out_valid_q;
  res_out_t   out_q, res_next;
  logic       match;
  logic [ExtW-1:0] dif_ext;

  assign dif_ext = ExtW'(dif_q);

  always_comb begin
    unique case (mode_q)
      MODE_EXACT:     match = (dif_q == '0);
      MODE_TOLERANCE: match = within_q;
      MODE_RMSE:      match = res_q[JOB_OVERALL][15:0] <= rmse_lim_q;
      MODE_PERCEPT:   match = res_q[JOB_LUMA] <= perc_lim_q;
      default:        match = 1'b0;
    endcase
    res_next = '0;
    if (cmd_i.acc) begin
      res_next.result_kind = KIND_DIFF;
      res_next.diff_red    = (absd_q[0] > 8'd63) ? 8'hFF : {absd_q[0][5:0], 2'b00};
      res_next.diff_green  = (absd_q[1] > 8'd63) ? 8'hFF : {absd_q[1][5:0], 2'b00};
      res_next.diff_blue   = (absd_q[2] > 8'd63) ? 8'hFF : {absd_q[2][5:0], 2'b00};
      res_next.last_result = !last_q;
    end else if (cmd_i.job == JOB_OVERALL) begin
      res_next.result_kind     = KIND_VERDICT;
      res_next.overall_rms     = res_q[JOB_OVERALL][15:0];
      res_next.luma_error      = res_q[JOB_LUMA];
      res_next.differing_count = (dif_ext > ExtW'(21'h1FFFFF)) ? '1 : dif_ext[20:0];
      res_next.matches_res     = match;
      res_next.last_result     = 1'b1;
    end else begin
      res_next.result_kind    = KIND_SUMMARY;
      res_next.channel_number = jch;
      res_next.max_error      = max_q[jch];
      res_next.channel_rms    = res_q[cmd_i.job][15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.acc || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc || cmd_i.emit) out_q <= res_next;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.last      = last_q;
endmodule
`default_nettype wire

// ----- rtl/idsc_ctrl.sv -----
// Controller: steps each pixel through the datapath and sequences the
// end-of-image divide, root and result emission. Depends on idsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idsc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output idsc_pkg::cmd_t       cmd_o,
  input  wire idsc_pkg::sts_t  sts_i
);
  import idsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_LUMA, S_ACC, S_DIV_GO, S_DIV_WAIT, S_SQ_GO, S_SQ_WAIT, S_EMIT
  } state_e;

  state_e     state_q;
  logic [2:0] job_q;

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    cmd_o         = '0;
    cmd_o.job     = job_q;
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul     = (state_q == S_MUL);
    cmd_o.luma    = (state_q == S_LUMA);
    cmd_o.acc     = (state_q == S_ACC) && sts_i.out_free;
    cmd_o.div_go  = (state_q == S_DIV_GO);
    cmd_o.sqrt_go = (state_q == S_SQ_GO);
    cmd_o.keep    = (state_q == S_SQ_WAIT) && sts_i.sqrt_done;
    cmd_o.emit    = (state_q == S_EMIT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_MUL;
        S_MUL:    state_q <= S_LUMA;
        S_LUMA:   state_q <= S_ACC;
        S_ACC: begin
          if (sts_i.out_free) begin
            job_q   <= '0;
            state_q <= sts_i.last ? S_DIV_GO : S_IDLE;
          end
        end
        S_DIV_GO:   state_q <= S_DIV_WAIT;
        S_DIV_WAIT: if (sts_i.div_done) state_q <= S_SQ_GO;
        S_SQ_GO:    state_q <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (sts_i.sqrt_done) begin
            if (job_q == JOB_LUMA) begin
              job_q   <= '0;
              state_q <= S_EMIT;
            end else begin
              job_q   <= job_q + 1'b1;
              state_q <= S_DIV_GO;
            end
          end
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (job_q == JOB_OVERALL) begin
              job_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              job_q <= job_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rgba_image_difference_stats_core.sv -----
// Top level of the RGBA image difference statistics core.
// Depends on idsc_pkg, idsc_ctrl and idsc_dp.
`timescale 1ns / 1ps
`default_nettype none
// Takes one reference/actual RGBA8 pixel pair per request and returns an
// amplified diff pixel for it; a pixel passes capture with table lookup,
// weight multiply, luma round and accumulate, and the next pixel is taken
// in the cycle after its diff pixel is loaded into the output register. On
// the pixel marked last the core runs six divide/root jobs (four channels,
// overall, luma) on a shared restoring divider and bit-serial square root,
// then emits four channel summaries and the verdict and clears its
// statistics. Configuration writes are taken at any time but belong in
// idle periods.
module rgba_image_difference_stats_core #(
  parameter int MAX_PIXELS = 1048576
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire idsc_pkg::pix_in_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output idsc_pkg::res_out_t              out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [2:0]                 cfg_index_i,
  input  wire logic [idsc_pkg::CfgW-1:0]  cfg_data_i
);
  import idsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  idsc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_o (cmd),
    .sts_i (sts)
  );

  idsc_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
    .clk_i, .rst_ni,
    .in_data_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_ready_i,
    .out_valid_o,
    .out_data_o,
    .cmd_i (cmd),
    .sts_o (sts)
  );
endmodule
`default_nettype wire

// ----- bench/idsc_checker.sv -----
// Checker for the RGBA image difference statistics core: watches the pixel,
// result and configuration channels, predicts every result and compares.
// Depends on idsc_pkg.
`timescale 1ns / 1ps
module idsc_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  idsc_pkg::pix_in_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  idsc_pkg::res_out_t        out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [2:0]                cfg_index_i,
  input  logic [idsc_pkg::CfgW-1:0] cfg_data_i,
  output int                        fail_count,
  output int                        pending,
  output int                        result_total,
  output int                        image_total
);
  import idsc_pkg::*;

  localparam longint unsigned SqTop  = (64'd1 << 36) - 1;
  localparam longint unsigned LsqTop = (64'd1 << 54) - 1;
  localparam longint unsigned PixCap = 64'd1048576;

  logic [15:0] lin_lut [256];

  // current settings
  logic [1:0]  mode_q;
  logic [7:0]  tol_q [4];
  logic [15:0] rmse_lim_q;
  logic [16:0] perc_lim_q;

  // image statistics
  longint unsigned sq_sum [4];
  logic [7:0]      ch_max [4];
  longint unsigned diff_cnt, pix_cnt, luma_sq;
  logic            in_tol;

  res_out_t expected_q[$];

  // exact search: largest v with (2v-1)^5 * 269025^12 <= num^12 * 2^85
  initial begin
    bit [383:0] dpow, rhs, lhs;
    int lo, hi, mid, v;
    dpow = 384'd1;
    repeat (12) dpow = dpow * 384'd269025;
    for (int n = 0; n < 256; n++) begin
      if (n <= 10) begin
        v = (655360 * n + 16473) / 32946;
      end else begin
        rhs = 384'd1;
        repeat (12) rhs = rhs * 384'(1000 * n + 14025);
        rhs = rhs << 85;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          lhs = dpow;
          repeat (5) lhs = lhs * 384'(2 * mid - 1);
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        v = lo;
      end
      lin_lut[n] = (v > 65535) ? 16'hFFFF : v[15:0];
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned acc;
    acc = 64'(W_RED) * lin_lut[r] + 64'(W_GREEN) * lin_lut[g] + 64'(W_BLUE) * lin_lut[b];
    return (acc + 64'd32768) >> 16;
  endfunction

  task automatic clear_stats();
    for (int c = 0; c < 4; c++) begin
      sq_sum[c] = 0;
      ch_max[c] = 0;
    end
    diff_cnt = 0;
    pix_cnt = 0;
    in_tol = 1'b1;
    luma_sq = 0;
  endtask

  task automatic absorb_pixel(pix_in_t p);
    logic [7:0] rv [4], av [4];
    longint unsigned d, s, lr, la, n, total, rms, overall, luma;
    bit differs;
    res_out_t r;
    rv = '{p.ref_red, p.ref_green, p.ref_blue, p.ref_alpha};
    av = '{p.act_red, p.act_green, p.act_blue, p.act_alpha};
    differs = 0;
    r = '0;
    r.result_kind = KIND_DIFF;
    for (int c = 0; c < 4; c++) begin
      d = (av[c] > rv[c]) ? av[c] - rv[c] : rv[c] - av[c];
      s = sq_sum[c] + d * d;
      sq_sum[c] = (s > SqTop) ? SqTop : s;
      if (d > ch_max[c]) ch_max[c] = d[7:0];
      if (d != 0) differs = 1;
      if (d > tol_q[c]) in_tol = 1'b0;
      s = (d * 4 > 255) ? 255 : d * 4;
      case (c)
        0: r.diff_red = s[7:0];
        1: r.diff_green = s[7:0];
        2: r.diff_blue = s[7:0];
        default: ;
      endcase
    end
    lr = luma_of(rv[0], rv[1], rv[2]);
    la = luma_of(av[0], av[1], av[2]);
    d = (la > lr) ? la - lr : lr - la;
    luma_sq += d * d;
    if (luma_sq > LsqTop) luma_sq = LsqTop;
    if (pix_cnt < PixCap) pix_cnt++;
    if (differs && diff_cnt < PixCap) diff_cnt++;
    r.last_result = !p.last_pixel;
    expected_q.push_back(r);
    if (p.last_pixel) begin
      n = (pix_cnt != 0) ? pix_cnt : 1;
      total = 0;
      for (int c = 0; c < 4; c++) begin
        r = '0;
        r.result_kind = KIND_SUMMARY;
        r.channel_number = c[1:0];
        r.max_error = ch_max[c];
        rms = int_sqrt((sq_sum[c] << 16) / n);
        r.channel_rms = (rms > 65535) ? 16'hFFFF : rms[15:0];
        total += sq_sum[c];
        expected_q.push_back(r);
      end
      overall = int_sqrt((total << 16) / (4 * n));
      if (overall > 65535) overall = 65535;
      luma = int_sqrt(luma_sq / n);
      if (luma > 65536) luma = 65536;
      r = '0;
      r.result_kind = KIND_VERDICT;
      r.overall_rms = overall[15:0];
      r.luma_error = luma[16:0];
      r.differing_count = diff_cnt[20:0];
      case (mode_q)
        MODE_EXACT:     r.matches_res = (diff_cnt == 0);
        MODE_TOLERANCE: r.matches_res = in_tol;
        MODE_RMSE:      r.matches_res = (overall <= rmse_lim_q);
        default:        r.matches_res = (luma <= perc_lim_q);
      endcase
      r.last_result = 1'b1;
      expected_q.push_back(r);
      image_total++;
      clear_stats();
    end
  endtask

  task automatic flag(string what, res_out_t exp_r, res_out_t got_r);
    if (fail_count < 10)
      $display("%t %s: expected %p, got %p", $realtime, what, exp_r, got_r);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_out_t e;
    if (!rst_ni) begin
      mode_q <= MODE_EXACT;
      for (int c = 0; c < 4; c++) tol_q[c] <= '0;
      rmse_lim_q <= '0;
      perc_lim_q <= '0;
      clear_stats();
      expected_q.delete();
      fail_count = 0;
      result_total = 0;
      image_total = 0;
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        result_total++;
        if (expected_q.size() == 0) begin
          flag("unexpected result", '0, out_data_i);
        end else begin
          e = expected_q.pop_front();
          if (out_data_i !== e) flag("result mismatch", e, out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) absorb_pixel(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:      mode_q <= cfg_data_i[1:0];
          REG_TOL_RED:   tol_q[0] <= cfg_data_i[7:0];
          REG_TOL_GREEN: tol_q[1] <= cfg_data_i[7:0];
          REG_TOL_BLUE:  tol_q[2] <= cfg_data_i[7:0];
          REG_TOL_ALPHA: tol_q[3] <= cfg_data_i[7:0];
          REG_RMSE:      rmse_lim_q <= cfg_data_i[15:0];
          REG_PERCEPT:   perc_lim_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      pending = expected_q.size();
    end
  end
endmodule

// ----- bench/rgba_image_difference_stats_core_tb.sv -----
// Testbench top for the RGBA image difference statistics core: clock, reset,
// pixel and configuration stimulus, receiver stalls and the verdict.
// Depends on idsc_pkg, idsc_checker and rgba_image_difference_stats_core.
`timescale 1ns / 1ps
module rgba_image_difference_stats_core_tb;
  import idsc_pkg::*;

  localparam int CycleLimit = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  pix_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  res_out_t          out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;

  int fail_count, pending, result_total, image_total;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int pixels_sent = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rgba_image_difference_stats_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  idsc_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count, .pending, .result_total, .image_total
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (cycles > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending);
      $display("rgba_image_difference_stats_core_tb: errors");
      $finish;
    end
  end

  task automatic send_pixel(pix_in_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CfgW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // hold requests until every expected result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic pix_in_t make_pixel(bit last);
    pix_in_t p;
    logic [7:0] r [4];
    int sel;
    p = '0;
    for (int c = 0; c < 4; c++) r[c] = 8'($urandom_range(255));
    sel = $urandom_range(9);
    p.ref_red = r[0];
    p.ref_green = r[1];
    p.ref_blue = r[2];
    p.ref_alpha = r[3];
    p.act_red = r[0];
    p.act_green = r[1];
    p.act_blue = r[2];
    p.act_alpha = r[3];
    if (sel >= 7) begin
      p.act_red = 8'($urandom_range(255));
      p.act_green = 8'($urandom_range(255));
      p.act_blue = 8'($urandom_range(255));
      p.act_alpha = 8'($urandom_range(255));
    end else if (sel >= 3) begin
      // small deviations, the interesting part for tolerance and rmse
      p.act_red = r[0] + 8'($urandom_range(6)) - 8'd3;
      p.act_green = r[1] + 8'($urandom_range(6)) - 8'd3;
      p.act_blue = r[2] + 8'($urandom_range(6)) - 8'd3;
      p.act_alpha = r[3] + 8'($urandom_range(6)) - 8'd3;
    end
    p.last_pixel = last;
    return p;
  endfunction

  task automatic send_image(int len);
    for (int i = 0; i < len; i++) send_pixel(make_pixel(i == len - 1));
  endtask

  function automatic pix_in_t pair(logic [7:0] a, logic [7:0] b, bit last);
    pix_in_t p;
    p = '{a, a, a, a, b, b, b, b, last};
    return p;
  endfunction

  task automatic configure(int mode, int tol, int rmse, int perc);
    // upper data bits are junk the register must drop
    write_reg(REG_MODE, mode | ($urandom_range(1) << 10));
    write_reg(REG_TOL_RED, tol);
    write_reg(REG_TOL_GREEN, (tol + 1) & 255);
    write_reg(REG_TOL_BLUE, tol | ($urandom_range(255) << 8));
    write_reg(REG_TOL_ALPHA, tol);
    write_reg(REG_RMSE, rmse | ($urandom_range(1) << 16));
    write_reg(REG_PERCEPT, perc);
  endtask

  initial begin
    int budget;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, saturation edge of the x4 gain, single-pixel image
    configure(MODE_EXACT, 0, 0, 0);
    send_pixel(pair(8'd0, 8'd0, 1'b1));
    send_pixel(pair(8'd0, 8'd255, 1'b0));
    send_pixel(pair(8'd255, 8'd0, 1'b0));
    send_pixel(pair(8'd100, 8'd163, 1'b0));
    send_pixel(pair(8'd100, 8'd164, 1'b0));
    send_pixel(pair(8'd11, 8'd10, 1'b1));
    send_pixel('{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1});
    drain();
    configure(MODE_TOLERANCE, 255, 65535, 65536);
    send_pixel(pair(8'd0, 8'd255, 1'b0));
    send_pixel(pair(8'd255, 8'd255, 1'b1));
    drain();
    configure(MODE_PERCEPT, 3, 0, 131071);
    send_pixel(pair(8'd10, 8'd11, 1'b0));
    send_pixel(pair(8'd1, 8'd2, 1'b1));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      configure((ph + 1) % 4, $urandom_range(6), $urandom_range(2000),
                $urandom_range(4000));
      budget = pixels_sent + 34;
      while (pixels_sent < budget) begin
        if ($urandom_range(9) == 0) send_image($urandom_range(20, 40));
        else send_image($urandom_range(1, 6));
      end
      drain();
    end

    recv_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    $display("covered %0d pixel requests, %0d images, %0d results, all compare modes",
             pixels_sent, image_total, result_total);
    if (fail_count == 0) begin
      $display("rgba_image_difference_stats_core_tb: clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("rgba_image_difference_stats_core_tb: errors");
    end
    $finish;
  end
endmodule
